// ===== rtl/core/tvss_pkg.sv =====
// Shared types, constants and the preset table of the three-voice sequencer.
// Used by tvss_lvl_div and three_voice_sfx_sequencer_core; depends on nothing.
`timescale 1ns / 1ps

package tvss_pkg;

  localparam int VOICE_COUNT_DEF = 3;
  localparam int FRAME_BYTES     = 26;
  localparam int GROUP_BYTES     = 7;

  // level*ticks_left width, also the number of divider steps
  localparam int PROD_W = 9;

  localparam logic [6:0]  LOUD_VOLUME   = 7'd120;
  localparam logic [3:0]  LEVEL_MAX     = 4'd15;
  localparam logic [15:0] FREQ_MAX      = 16'd65535;
  localparam logic [7:0]  FR_CTRL_VALUE = 8'h08;
  localparam logic [7:0]  FR_WAVE_GATE  = 8'h01;
  localparam logic [7:0]  FR_ENV_VALUE  = 8'h02;
  localparam logic [3:0]  FR_LVL_LOW    = 4'h2;
  localparam logic [7:0]  FR_VOL_ON     = 8'd15;

  // byte offsets inside one voice group of the frame
  localparam logic [2:0] OFF_FREQ_LO = 3'd0;
  localparam logic [2:0] OFF_FREQ_HI = 3'd1;
  localparam logic [2:0] OFF_PAD     = 3'd2;
  localparam logic [2:0] OFF_CTRL    = 3'd3;
  localparam logic [2:0] OFF_WAVE    = 3'd4;
  localparam logic [2:0] OFF_ENV     = 3'd5;
  localparam logic [2:0] OFF_LEVEL   = 3'd6;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_TICK      = 3'd2,
    OP_RESET_ALL = 3'd3,
    OP_READ      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_RD_ISSUE,
    ST_RD_LOAD,
    ST_RD_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] slide;
    logic [4:0]  ticks;
    logic [4:0]  dur;
    logic [3:0]  level;
    logic [7:0]  wave;
    logic        retrig;
  } voice_t;

  typedef struct packed {
    logic        active;
    logic        retrig;
    logic [15:0] freq;
    logic [7:0]  wave;
    logic [3:0]  lvl;
  } snap_t;

  typedef struct packed {
    logic [7:0]  wave;
    logic [15:0] freq;
    logic [15:0] slide;
    logic [4:0]  dur;
  } preset_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [4:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [3:0] quotient;
  } div_rsp_t;

  function automatic preset_t preset_lookup(input logic [2:0] cls);
    preset_t p;
    unique case (cls)
      3'd0:    p = '{wave: 8'h20, freq: 16'd2800,  slide: 16'hFF9C, dur: 5'd9};
      3'd1:    p = '{wave: 8'h80, freq: 16'd13000, slide: 16'hF894, dur: 5'd5};
      3'd2:    p = '{wave: 8'h80, freq: 16'd17000, slide: 16'hFB50, dur: 5'd10};
      3'd3:    p = '{wave: 8'h80, freq: 16'd9000,  slide: 16'hFF9C, dur: 5'd3};
      3'd4:    p = '{wave: 8'h40, freq: 16'd1900,  slide: 16'd35,   dur: 5'd18};
      3'd5:    p = '{wave: 8'h10, freq: 16'd8500,  slide: 16'd600,  dur: 5'd8};
      3'd6:    p = '{wave: 8'h20, freq: 16'd2200,  slide: 16'hFF56, dur: 5'd7};
      default: p = '{wave: 8'h80, freq: 16'd6000,  slide: 16'hFF24, dur: 5'd18};
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/three_voice_sfx_sequencer_core.sv =====
// Top level of the three-voice sound-effect sequencer.
// Uses tvss_pkg, tvss_ram (voice state) and tvss_lvl_div (frame level).
`timescale 1ns / 1ps
//
// Usage:
//   in_* carries commands: in_tuser is the opcode, in_tdata the arguments.
//   out_* carries results: one status transfer per start, 26 frame-byte
//   transfers per read (out_tlast on byte 25). Stop, tick, reset all and
//   unused opcodes produce nothing.
// Command handling:
//   start loads its status into the output register, stop clears
//   one valid bit and reset all clears them all, tick reads then writes
//   back one RAM entry per voice, read does per voice a RAM read, then a
//   9-step bit-serial division for the level, followed by the frame bytes.
//   A new command is taken only when the previous one is done; the pending
//   result may still sit in the output register at that time.
// Reset clears all per-entry valid bits, so every voice reads as silent;
// no clearing pass is needed. When out_tready is low the output register
// holds and a frame read pauses until the byte is taken.

module three_voice_sfx_sequencer_core #(
  parameter int VOICE_COUNT = tvss_pkg::VOICE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  input  logic [15:0] in_tdata,   // [1:0] channel, [4:2] preset_class, [5] sound_known,
                                  // [12:6] volume_request, [15:13] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] status, [5:1] byte_index, [13:6] byte_value,
                                  // [15:14] zero
  output logic        out_tlast   // last
);

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int EW = $bits(tvss_pkg::voice_t);

  tvss_pkg::state_t state_r, state_nxt;
  logic [VW-1:0]    voice_r, voice_nxt;
  logic [VOICE_COUNT-1:0] valid_r, valid_nxt;
  tvss_pkg::snap_t  snap_r [VOICE_COUNT];
  tvss_pkg::snap_t  snap_nxt [VOICE_COUNT];
  logic [4:0]       byte_r, byte_nxt;
  logic [1:0]       grp_r, grp_nxt;
  logic [2:0]       off_r, off_nxt;
  logic             status_r, status_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [4:0]       out_idx_r, out_idx_nxt;
  logic [7:0]       out_val_r, out_val_nxt;
  logic             out_last_r, out_last_nxt;

  logic             wr_en;
  logic [VW-1:0]    wr_addr;
  tvss_pkg::voice_t wr_data;
  tvss_pkg::voice_t rd_data;
  tvss_pkg::voice_t ent;
  tvss_pkg::voice_t ent_tick;
  tvss_pkg::voice_t ent_start;
  tvss_pkg::preset_t preset;
  tvss_pkg::div_req_t div_req;
  tvss_pkg::div_rsp_t div_rsp;

  logic [1:0]       in_ch;
  logic [2:0]       in_cls;
  logic             in_known;
  logic [6:0]       in_vol;
  tvss_pkg::op_t    in_op;
  logic             ch_ok;
  logic [3:0]       start_level;
  logic [17:0]      freq_sum;
  logic             out_free;
  logic             last_voice;
  logic             grp_ok;
  tvss_pkg::snap_t  grp_snap;
  logic [7:0]       retrig_byte;
  logic             any_active;
  logic [7:0]       emit_val;

  assign in_op    = tvss_pkg::op_t'(in_tuser);
  assign in_ch    = in_tdata[1:0];
  assign in_cls   = in_tdata[4:2];
  assign in_known = in_tdata[5];
  assign in_vol   = in_tdata[12:6];
  assign ch_ok    = {1'b0, in_ch} < 3'(VOICE_COUNT);

  assign in_tready = (state_r == tvss_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign last_voice = (voice_r == VW'(VOICE_COUNT - 1));

  tvss_ram #(
    .WIDTH (EW),
    .DEPTH (VOICE_COUNT),
    .AW    (VW)
  ) u_voice_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (voice_r),
    .rd_data (rd_data)
  );

  tvss_lvl_div u_lvl_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // an entry never written since reset, stop or clear reads as zero
  assign ent = valid_r[voice_r] ? rd_data : '0;

  assign freq_sum = 18'({2'b00, ent.freq}) + {{2{ent.slide[15]}}, ent.slide};

  always_comb begin
    ent_tick        = ent;
    ent_tick.retrig = 1'b0;
    if (ent.ticks != 5'd0) begin
      ent_tick.ticks = ent.ticks - 5'd1;
      if ($signed(freq_sum) < 18'sd1) begin
        ent_tick.freq = 16'd1;
      end else if ($signed(freq_sum) > $signed({2'b00, tvss_pkg::FREQ_MAX})) begin
        ent_tick.freq = tvss_pkg::FREQ_MAX;
      end else begin
        ent_tick.freq = freq_sum[15:0];
      end
    end
  end

  assign preset      = tvss_pkg::preset_lookup(in_cls);
  assign start_level = (in_vol >= tvss_pkg::LOUD_VOLUME) ? tvss_pkg::LEVEL_MAX
                                                         : 4'(({1'b0, in_vol} + 8'd7) >> 3);

  always_comb begin
    ent_start.freq   = preset.freq;
    ent_start.slide  = preset.slide;
    ent_start.ticks  = preset.dur;
    ent_start.dur    = preset.dur;
    ent_start.level  = start_level;
    ent_start.wave   = preset.wave;
    ent_start.retrig = 1'b1;
  end

  // frame byte source
  assign grp_ok   = grp_r < 2'(VOICE_COUNT);
  assign grp_snap = snap_r[grp_r[VW-1:0]];

  always_comb begin
    retrig_byte = '0;
    any_active  = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      retrig_byte[i] = snap_r[i].active && snap_r[i].retrig;
      any_active     = any_active || snap_r[i].active;
    end
  end

  always_comb begin
    emit_val = '0;
    if (byte_r == 5'd0) begin
      emit_val = retrig_byte;
    end else if (byte_r == 5'(tvss_pkg::FRAME_BYTES - 1)) begin
      emit_val = any_active ? tvss_pkg::FR_VOL_ON : 8'd0;
    end else if (grp_ok && grp_snap.active) begin
      unique case (off_r)
        tvss_pkg::OFF_FREQ_LO: emit_val = grp_snap.freq[7:0];
        tvss_pkg::OFF_FREQ_HI: emit_val = grp_snap.freq[15:8];
        tvss_pkg::OFF_PAD:     emit_val = 8'd0;
        tvss_pkg::OFF_CTRL:    emit_val = tvss_pkg::FR_CTRL_VALUE;
        tvss_pkg::OFF_WAVE:    emit_val = grp_snap.wave | tvss_pkg::FR_WAVE_GATE;
        tvss_pkg::OFF_ENV:     emit_val = tvss_pkg::FR_ENV_VALUE;
        tvss_pkg::OFF_LEVEL:   emit_val = {grp_snap.lvl, tvss_pkg::FR_LVL_LOW};
        default:               emit_val = 8'd0;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    voice_nxt      = voice_r;
    valid_nxt      = valid_r;
    snap_nxt       = snap_r;
    byte_nxt       = byte_r;
    grp_nxt        = grp_r;
    off_nxt        = off_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_val_nxt    = out_val_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = voice_r;
    wr_data        = ent_tick;
    div_req        = '0;

    unique case (state_r)
      tvss_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_op)
            tvss_pkg::OP_START: begin
              status_nxt = !(ch_ok && in_known);
              if (ch_ok && in_known) begin
                valid_nxt[in_ch[VW-1:0]] = (in_vol != 7'd0);
                wr_en   = (in_vol != 7'd0);
                wr_addr = in_ch[VW-1:0];
                wr_data = ent_start;
              end
              state_nxt = tvss_pkg::ST_RESP;
            end
            tvss_pkg::OP_STOP: begin
              if (ch_ok) begin
                valid_nxt[in_ch[VW-1:0]] = 1'b0;
              end
            end
            tvss_pkg::OP_TICK: begin
              voice_nxt = '0;
              state_nxt = tvss_pkg::ST_TICK_RD;
            end
            tvss_pkg::OP_RESET_ALL: begin
              valid_nxt = '0;
            end
            tvss_pkg::OP_READ: begin
              voice_nxt = '0;
              state_nxt = tvss_pkg::ST_RD_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end

      tvss_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_idx_nxt    = '0;
          out_val_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = tvss_pkg::ST_IDLE;
        end
      end

      tvss_pkg::ST_TICK_RD: begin
        state_nxt = tvss_pkg::ST_TICK_WR;
      end

      tvss_pkg::ST_TICK_WR: begin
        wr_en = valid_r[voice_r];
        if (last_voice) begin
          state_nxt = tvss_pkg::ST_IDLE;
        end else begin
          voice_nxt = voice_r + VW'(1);
          state_nxt = tvss_pkg::ST_TICK_RD;
        end
      end

      tvss_pkg::ST_RD_ISSUE: begin
        state_nxt = tvss_pkg::ST_RD_LOAD;
      end

      tvss_pkg::ST_RD_LOAD: begin
        snap_nxt[voice_r].active = (ent.ticks != 5'd0);
        snap_nxt[voice_r].retrig = ent.retrig;
        snap_nxt[voice_r].freq   = ent.freq;
        snap_nxt[voice_r].wave   = ent.wave;
        div_req.start    = 1'b1;
        div_req.dividend = {5'd0, ent.level} * {4'd0, ent.ticks};
        div_req.divisor  = ent.dur;
        state_nxt = tvss_pkg::ST_RD_DIV;
      end

      tvss_pkg::ST_RD_DIV: begin
        if (div_rsp.done) begin
          snap_nxt[voice_r].lvl = div_rsp.quotient;
          if (last_voice) begin
            byte_nxt  = '0;
            grp_nxt   = '0;
            off_nxt   = '0;
            state_nxt = tvss_pkg::ST_EMIT;
          end else begin
            voice_nxt = voice_r + VW'(1);
            state_nxt = tvss_pkg::ST_RD_ISSUE;
          end
        end
      end

      tvss_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_idx_nxt    = byte_r;
          out_val_nxt    = emit_val;
          out_last_nxt   = (byte_r == 5'(tvss_pkg::FRAME_BYTES - 1));
          if (byte_r == 5'(tvss_pkg::FRAME_BYTES - 1)) begin
            state_nxt = tvss_pkg::ST_IDLE;
          end else begin
            byte_nxt = byte_r + 5'd1;
            // advance the voice group walk on group bytes only
            if (byte_r != 5'd0) begin
              if (off_r == 3'(tvss_pkg::GROUP_BYTES - 1)) begin
                off_nxt = '0;
                grp_nxt = grp_r + 2'd1;
              end else begin
                off_nxt = off_r + 3'd1;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = tvss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tvss_pkg::ST_IDLE;
      valid_r     <= '0;
      voice_r     <= '0;
      byte_r      <= '0;
      grp_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      voice_r     <= voice_nxt;
      byte_r      <= byte_nxt;
      grp_r       <= grp_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r       <= snap_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_val_r    <= out_val_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r, out_idx_r, out_status_r};
  assign out_tlast  = out_last_r;

  a_read_enters_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == tvss_pkg::OP_READ
      |=> state_r == tvss_pkg::ST_RD_ISSUE)
    else $error("read command did not start the voice fetch");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_idx_r <= 5'(tvss_pkg::FRAME_BYTES - 1))
    else $error("frame byte index beyond the frame");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_idx_r == 5'(tvss_pkg::FRAME_BYTES - 1) |-> out_last_r)
    else $error("final frame byte without last");

  a_no_write_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tvss_pkg::ST_EMIT |-> !wr_en)
    else $error("voice RAM written during frame output");

endmodule

// ===== rtl/core/tvss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the per-voice state; depends on nothing.
`timescale 1ns / 1ps

module tvss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/tvss_lvl_div.sv =====
// Bit-serial restoring divider for the frame level: (level*ticks_left)/duration.
// One quotient bit per cycle; uses tvss_pkg.
`timescale 1ns / 1ps

module tvss_lvl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tvss_pkg::div_req_t req,
  output tvss_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(tvss_pkg::PROD_W + 1);

  logic [tvss_pkg::PROD_W-1:0] quo_r, quo_nxt;
  logic [4:0]                  rem_r, rem_nxt;
  logic [4:0]                  div_r, div_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [5:0]                  trial;

  assign trial = {rem_r, quo_r[tvss_pkg::PROD_W-1]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = CW'(tvss_pkg::PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift one dividend bit in, subtract when it fits
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = 5'(trial - {1'b0, div_r});
        quo_nxt = {quo_r[tvss_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[4:0];
        quo_nxt = {quo_r[tvss_pkg::PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // zero duration reads as level zero
  assign rsp.done     = done_r;
  assign rsp.quotient = (div_r == 5'd0) ? 4'd0 : quo_r[3:0];

endmodule
